// ----- src/h2fe_pkg.sv -----
// Shared types, codes and constant tables of the HTTP/2 server frame engine.
// No dependencies; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package h2fe_pkg;

   // configuration port
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;
   localparam logic [1:0] CSR_IDX_MCS = 2'd0;
   localparam logic [1:0] CSR_IDX_IWS = 2'd1;
   localparam logic [1:0] CSR_IDX_MFS = 2'd2;
   localparam logic [1:0] CSR_IDX_GEC = 2'd3;
   localparam logic [31:0] RST_MCS = 32'd100;
   localparam logic [30:0] RST_IWS = 31'd65535;
   localparam logic [23:0] RST_MFS = 24'd16384;
   localparam logic [31:0] RST_GEC = 32'd0;

   // request codes
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_CLOSE = 2'd1;
   localparam logic [1:0] REQ_ERROR = 2'd2;

   // frame types and flags
   localparam logic [7:0] FT_HEADERS   = 8'h01;
   localparam logic [7:0] FT_SETTINGS  = 8'h04;
   localparam logic [7:0] FT_GOAWAY    = 8'h07;
   localparam logic [7:0] FLAG_ACK     = 8'h01;
   localparam logic [7:0] FLAGS_HDRRSP = 8'h05;
   localparam logic [7:0] STATUS_200   = 8'h88;

   localparam logic [4:0] PREFACE_LAST = 5'd23;
   localparam logic [3:0] HDR_LAST     = 4'd8;

   // job queue
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);

   typedef enum logic [2:0] {
      PH_PREFACE = 3'd0,
      PH_FRAMES  = 3'd1,
      PH_GOAWAY  = 3'd2,
      PH_PROTERR = 3'd3,
      PH_CLOSED  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SETTINGS,
      ACT_ACK,
      ACT_HEADERS,
      ACT_GOAWAY
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [30:0] stream;
      phase_type   phase;
   } job_type;

   typedef struct packed {
      logic [31:0] mcs;
      logic [30:0] iws;
      logic [23:0] mfs;
      logic [31:0] gec;
   } csr_type;

   // index of the final word of each job
   function automatic logic [4:0] job_last(input action_type a);
      logic [4:0] n;
      unique case (a)
         ACT_SETTINGS: n = 5'd26;
         ACT_ACK:      n = 5'd8;
         ACT_HEADERS:  n = 5'd9;
         ACT_GOAWAY:   n = 5'd16;
         default:      n = 5'd0;
      endcase
      return n;
   endfunction

   // client connection preface
   function automatic logic [7:0] preface_byte(input logic [4:0] i);
      logic [7:0] c;
      unique case (i)
         5'd0:  c = 8'h50;  // P
         5'd1:  c = 8'h52;  // R
         5'd2:  c = 8'h49;  // I
         5'd3:  c = 8'h20;
         5'd4:  c = 8'h2A;  // *
         5'd5:  c = 8'h20;
         5'd6:  c = 8'h48;  // H
         5'd7:  c = 8'h54;  // T
         5'd8:  c = 8'h54;  // T
         5'd9:  c = 8'h50;  // P
         5'd10: c = 8'h2F;  // /
         5'd11: c = 8'h32;  // 2
         5'd12: c = 8'h2E;  // .
         5'd13: c = 8'h30;  // 0
         5'd14: c = 8'h0D;
         5'd15: c = 8'h0A;
         5'd16: c = 8'h0D;
         5'd17: c = 8'h0A;
         5'd18: c = 8'h53;  // S
         5'd19: c = 8'h4D;  // M
         5'd20: c = 8'h0D;
         5'd21: c = 8'h0A;
         5'd22: c = 8'h0D;
         5'd23: c = 8'h0A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // residue modulo 3 by summing base-4 digits (4 = 1 mod 3)
   function automatic logic [1:0] mod3(input logic [7:0] v);
      logic [3:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
      t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
      u = {1'b0, t[1:0]} + {2'b00, t[2]};
      return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/h2fe_if.sv -----
// Valid/ready channel interfaces of the frame engine: request and response.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface h2fe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface h2fe_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       last;
   logic [2:0] conn_phase;

   modport source (output valid, output tx_valid, output tx_byte, output last,
                   output conn_phase, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input last,
                   input conn_phase, output ready);
endinterface

`default_nettype wire

// ----- src/h2fe_front.sv -----
// Front end: matches the preface, parses frame headers, counts payload and
// turns each accepted word into one job for the back end. Depends on h2fe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2fe_front
   import h2fe_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   h2fe_req_if.sink   req_if,
   output job_type    push_job,
   output logic       push,
   input  wire logic  q_full
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  pref_cnt_ff, pref_cnt_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [23:0] len_ff, len_in;
   logic [1:0]  len_mod3_ff, len_mod3_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  flags_ff, flags_in;
   logic [30:0] stream_ff, stream_in;
   logic [23:0] left_ff, left_in;
   logic        accept;
   logic        frame_done;
   action_type  action;
   logic [7:0]  b;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign b            = req_if.rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      pref_cnt_in = pref_cnt_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      len_in      = len_ff;
      len_mod3_in = len_mod3_ff;
      kind_in     = kind_ff;
      flags_in    = flags_ff;
      stream_in   = stream_ff;
      left_in     = left_ff;
      frame_done  = 1'b0;
      action      = ACT_NONE;

      if (accept && (phase_ff == PH_PREFACE || phase_ff == PH_FRAMES)) begin
         priority if (req_if.req_type == REQ_CLOSE) begin
            phase_in = PH_CLOSED;
         end else if (req_if.req_type == REQ_ERROR) begin
            phase_in = PH_PROTERR;
         end else if (req_if.req_type == REQ_BYTE) begin
            if (phase_ff == PH_PREFACE) begin
               if (preface_byte(pref_cnt_ff) == b) begin
                  pref_cnt_in = pref_cnt_ff + 5'd1;
                  if (pref_cnt_ff == PREFACE_LAST) begin
                     action   = ACT_SETTINGS;
                     phase_in = PH_FRAMES;
                  end
               end else begin
                  phase_in = PH_PROTERR;
               end
            end else if (left_ff != '0) begin
               left_in    = left_ff - 24'd1;
               frame_done = (left_ff == 24'd1);
            end else begin
               unique case (hdr_cnt_ff)
                  4'd0: begin
                     len_in      = {b, 16'h0000};
                     len_mod3_in = mod3(b);
                  end
                  4'd1: begin
                     len_in[15:8] = b;
                     len_mod3_in  = mod3({6'b0, len_mod3_ff} + {6'b0, mod3(b)});
                  end
                  4'd2: begin
                     len_in[7:0] = b;
                     len_mod3_in = mod3({6'b0, len_mod3_ff} + {6'b0, mod3(b)});
                  end
                  4'd3: kind_in  = b;
                  4'd4: flags_in = b;
                  4'd5: stream_in = {b[6:0], 24'h000000};
                  4'd6: stream_in[23:16] = b;
                  4'd7: stream_in[15:8]  = b;
                  default: stream_in[7:0] = b;
               endcase
               if (hdr_cnt_ff == HDR_LAST) begin
                  hdr_cnt_in = '0;
                  left_in    = len_ff;
                  frame_done = (len_ff == '0);
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 4'd1;
               end
            end

            // act on a completed frame
            if (frame_done) begin
               if (kind_ff == FT_SETTINGS) begin
                  if ((flags_ff & FLAG_ACK) == 8'h00) begin
                     if (!len_ff[0] && len_mod3_ff == 2'd0) begin
                        action = ACT_ACK;
                     end else begin
                        phase_in = PH_PROTERR;
                     end
                  end
               end else if (kind_ff == FT_HEADERS) begin
                  action = ACT_HEADERS;
               end else if (kind_ff == FT_GOAWAY) begin
                  action   = ACT_GOAWAY;
                  phase_in = PH_GOAWAY;
               end
            end
         end else begin
            // unused request code: state is left as it is
         end
      end
   end

   // every accepted word yields a job, even one with nothing to send
   assign push            = accept;
   assign push_job.action = action;
   assign push_job.stream = stream_in;
   assign push_job.phase  = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREFACE;
         pref_cnt_ff <= '0;
         hdr_cnt_ff  <= '0;
         len_ff      <= '0;
         len_mod3_ff <= '0;
         kind_ff     <= '0;
         flags_ff    <= '0;
         stream_ff   <= '0;
         left_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         pref_cnt_ff <= pref_cnt_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         len_ff      <= len_in;
         len_mod3_ff <= len_mod3_in;
         kind_ff     <= kind_in;
         flags_ff    <= flags_in;
         stream_ff   <= stream_in;
         left_ff     <= left_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/h2fe_queue.sv -----
// Short job queue between front and back end of the frame engine.
// Depends on h2fe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2fe_queue
   import h2fe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         nonempty
);

   job_type            slot_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]     count_ff, count_in;

   assign full     = (count_ff == (QPtrW+1)'(QDepth));
   assign nonempty = (count_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- src/h2fe_back.sv -----
// Back end: plays each job out as transmit words into a registered response
// stage, one per cycle unless the stage is stalled. Depends on h2fe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2fe_back
   import h2fe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire csr_type csr,
   input  wire job_type q_head,
   input  wire logic    q_nonempty,
   output logic         pop,
   h2fe_rsp_if.source   rsp_if
);

   function automatic logic [7:0] frame_byte(input action_type a, input logic [4:0] i,
                                             input logic [30:0] s, input csr_type c);
      logic [31:0] iws;
      logic [31:0] mfs;
      logic [7:0]  r;
      iws = {1'b0, c.iws};
      mfs = {8'h00, c.mfs};
      r   = 8'h00;
      unique case (a)
         ACT_SETTINGS: begin
            unique case (i)
               5'd2:  r = 8'd18;
               5'd3:  r = FT_SETTINGS;
               5'd10: r = 8'h03;
               5'd11: r = c.mcs[31:24];
               5'd12: r = c.mcs[23:16];
               5'd13: r = c.mcs[15:8];
               5'd14: r = c.mcs[7:0];
               5'd16: r = 8'h04;
               5'd17: r = iws[31:24];
               5'd18: r = iws[23:16];
               5'd19: r = iws[15:8];
               5'd20: r = iws[7:0];
               5'd22: r = 8'h05;
               5'd23: r = mfs[31:24];
               5'd24: r = mfs[23:16];
               5'd25: r = mfs[15:8];
               5'd26: r = mfs[7:0];
               default: r = 8'h00;
            endcase
         end
         ACT_ACK: begin
            unique case (i)
               5'd3:    r = FT_SETTINGS;
               5'd4:    r = FLAG_ACK;
               default: r = 8'h00;
            endcase
         end
         ACT_HEADERS: begin
            unique case (i)
               5'd2:    r = 8'd1;
               5'd3:    r = FT_HEADERS;
               5'd4:    r = FLAGS_HDRRSP;
               5'd5:    r = {1'b0, s[30:24]};
               5'd6:    r = s[23:16];
               5'd7:    r = s[15:8];
               5'd8:    r = s[7:0];
               5'd9:    r = STATUS_200;
               default: r = 8'h00;
            endcase
         end
         ACT_GOAWAY: begin
            unique case (i)
               5'd2:    r = 8'd8;
               5'd3:    r = FT_GOAWAY;
               5'd12:   r = 8'd1;
               5'd13:   r = c.gec[31:24];
               5'd14:   r = c.gec[23:16];
               5'd15:   r = c.gec[15:8];
               5'd16:   r = c.gec[7:0];
               default: r = 8'h00;
            endcase
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   logic       busy_ff, busy_in;
   job_type    work_ff, work_in;
   logic [4:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_tx_valid_ff, out_tx_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic [2:0] out_phase_ff, out_phase_in;

   job_type    cur;
   logic [4:0] idx;
   logic       can_load;
   logic       produce;
   logic       is_last;

   always_comb begin
      cur      = busy_ff ? work_ff : q_head;
      idx      = busy_ff ? idx_ff : 5'd0;
      can_load = !out_valid_ff || rsp_if.ready;
      produce  = can_load && (busy_ff || q_nonempty);
      pop      = produce && !busy_ff;
      is_last  = (idx == job_last(cur.action));

      busy_in         = busy_ff;
      work_in         = work_ff;
      idx_in          = idx_ff;
      out_valid_in    = can_load ? produce : out_valid_ff;
      out_tx_valid_in = out_tx_valid_ff;
      out_byte_in     = out_byte_ff;
      out_last_in     = out_last_ff;
      out_phase_in    = out_phase_ff;

      if (produce) begin
         busy_in         = !is_last;
         work_in         = cur;
         idx_in          = idx + 5'd1;
         out_tx_valid_in = (cur.action != ACT_NONE);
         out_byte_in     = frame_byte(cur.action, idx, cur.stream, csr);
         out_last_in     = is_last;
         out_phase_in    = cur.phase;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.tx_valid   = out_tx_valid_ff;
   assign rsp_if.tx_byte    = out_byte_ff;
   assign rsp_if.last       = out_last_ff;
   assign rsp_if.conn_phase = out_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      work_ff         <= work_in;
      out_tx_valid_ff <= out_tx_valid_in;
      out_byte_ff     <= out_byte_in;
      out_last_ff     <= out_last_in;
      out_phase_ff    <= out_phase_in;
   end

endmodule

`default_nettype wire

// ----- src/http2_server_frame_engine.sv -----
// Top level of the HTTP/2 server frame engine: configuration registers and
// the front end, job queue and back end. Depends on h2fe_pkg and h2fe_if.
`timescale 1ns / 1ps
`default_nettype none

// The engine takes one request word per clock while its job queue is not
// full: a received byte or a link event. It checks the 24-byte client
// preface, then parses each frame's 9-byte header and counts its payload
// off. Every request word produces at least one response word: either the
// bytes of a reply frame (27-byte server SETTINGS after the preface, 9-byte
// SETTINGS ACK, 10-byte ':status 200' HEADERS, 17-byte GOAWAY), one byte per
// word with last on the final one, or a single word with tx_valid low that
// only reports the connection phase. The front end decides everything in
// the cycle the word is accepted and posts a job into a four-entry queue;
// while the response channel is ready, the back end plays jobs out at one
// response word per clock through a registered output stage, so single-word
// requests flow at the same rate. While a reply frame occupies the back end,
// the request side keeps accepting until the queue is full. The
// configuration registers (APB, byte address 4*i) are read by the back end
// while it builds frames, so write them only while the engine is idle.

module http2_server_frame_engine
   import h2fe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   h2fe_req_if.sink                 req_if,
   h2fe_rsp_if.source               rsp_if,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready
);

   csr_type    csr_ff, csr_in;
   logic       csr_write;
   logic [1:0] csr_idx;

   job_type    push_job;
   logic       push;
   logic       q_full;
   job_type    q_head;
   logic       q_nonempty;
   logic       pop;

   // register file: no wait states
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CsrAddrW-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_IDX_MCS: csr_in.mcs = csr_pwdata;
            CSR_IDX_IWS: csr_in.iws = csr_pwdata[30:0];
            CSR_IDX_MFS: csr_in.mfs = csr_pwdata[23:0];
            CSR_IDX_GEC: csr_in.gec = csr_pwdata;
         endcase
      end
   end

   // readback: unused upper bits read as zero
   always_comb begin
      unique case (csr_idx)
         CSR_IDX_MCS: csr_prdata = csr_ff.mcs;
         CSR_IDX_IWS: csr_prdata = {1'b0, csr_ff.iws};
         CSR_IDX_MFS: csr_prdata = {8'h00, csr_ff.mfs};
         CSR_IDX_GEC: csr_prdata = csr_ff.gec;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.mcs <= RST_MCS;
         csr_ff.iws <= RST_IWS;
         csr_ff.mfs <= RST_MFS;
         csr_ff.gec <= RST_GEC;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // parse and classify
   h2fe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .push_job (push_job),
      .push     (push),
      .q_full   (q_full)
   );

   // hold jobs while the back end is busy with a long frame
   h2fe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (q_head),
      .nonempty (q_nonempty)
   );

   // emit reply bytes
   h2fe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_head     (q_head),
      .q_nonempty (q_nonempty),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

// ----- src/h2fe_checker.sv -----
// Port-level checks on the response channel of the frame engine, and the
// bind that attaches them to the top level. Depends on h2fe_if.
`timescale 1ns / 1ps
`default_nettype none

module h2fe_checker (
   input wire logic   clock,
   input wire logic   reset,
   h2fe_rsp_if.source rsp_if
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.tx_byte) && $stable(rsp_if.last)
         && $stable(rsp_if.tx_valid) && $stable(rsp_if.conn_phase))
      else $error("response word changed while stalled");

   // a word without a byte is always the only word of its request
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.tx_valid |-> rsp_if.last && rsp_if.tx_byte == 8'h00)
      else $error("empty response word is not a lone last word with zero byte");

   // a frame is sent without gaps and under one phase
   a_frame_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last |=>
         rsp_if.valid && rsp_if.tx_valid && rsp_if.conn_phase == $past(rsp_if.conn_phase))
      else $error("gap or phase change inside an outgoing frame");

   // output stage empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

bind http2_server_frame_engine h2fe_checker u_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_if (rsp_if)
);

`default_nettype wire
